[src/pacu_pkg.sv]
// Shared types and constants for the primitive assembler with cull-order selection.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package pacu_pkg;

  localparam int unsigned REF_BITS_DEF  = 16;
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned KIND_BITS     = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_POINTS = 3'd0,
    KIND_LINES  = 3'd1,
    KIND_TRIS   = 3'd2,
    KIND_STRIP  = 3'd3,
    KIND_FAN    = 3'd4,
    KIND_RECTS  = 3'd5
  } prim_kind_e;

  typedef enum logic [1:0] {
    REG_PRIM_KIND  = 2'd0,
    REG_CULL_EN    = 2'd1,
    REG_CULL_MODE  = 2'd2,
    REG_CLEAR_MODE = 2'd3
  } reg_idx_e;

  localparam logic SHAPE_TRI  = 1'b0;
  localparam logic SHAPE_RECT = 1'b1;

  localparam logic [1:0] SKIP_RESET = 2'd2;
  localparam logic [1:0] SKIP_HUB   = 2'd1;

endpackage

`default_nettype wire

[src/pacu_if.sv]
// Handshake interfaces for vertex transactions in and primitive transactions out.
// Widths follow REF_BITS; defaults come from pacu_pkg.
`default_nettype none

interface pacu_vtx_if #(
  parameter int unsigned REF_BITS = pacu_pkg::REF_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [REF_BITS-1:0] vertex_ref;
  logic                outside;
  logic                new_draw;

  modport source (output valid, output vertex_ref, output outside, output new_draw,
                  input ready);
  modport sink   (input valid, input vertex_ref, input outside, input new_draw,
                  output ready);
endinterface

interface pacu_prim_if #(
  parameter int unsigned REF_BITS = pacu_pkg::REF_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                prim_shape;
  logic [REF_BITS-1:0] ref_a;
  logic [REF_BITS-1:0] ref_b;
  logic [REF_BITS-1:0] ref_c;
  logic                last;

  modport source (output valid, output prim_shape, output ref_a, output ref_b,
                  output ref_c, output last, input ready);
  modport sink   (input valid, input prim_shape, input ref_a, input ref_b,
                  input ref_c, input last, output ready);
endinterface

`default_nettype wire

[src/primitive_assembler_cull_order_unit.sv]
// A vertex's first primitive is registered, offered the cycle after its transaction.
// Throughput: one vertex per cycle while the output is ready and each causes at most
// one primitive; a vertex with both windings holds the single port until both leave.
// A vertex enters only when the buffer is empty or its one primitive leaves that cycle.
// Reset (rst_ni low, asynchronous): state registers to power-on values, buffer empty.
// Depends on pacu_pkg and pacu_if.sv.
`default_nettype none

module primitive_assembler_cull_order_unit #(
  parameter int unsigned REF_BITS = pacu_pkg::REF_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  pacu_vtx_if.sink                                  vtx_i,
  pacu_prim_if.source                               prim_o,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pacu_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [pacu_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic      [pacu_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                      pready
);
  import pacu_pkg::*;

  typedef struct packed {
    logic                shape;
    logic [REF_BITS-1:0] a;
    logic [REF_BITS-1:0] b;
    logic [REF_BITS-1:0] c;
    logic                last;
  } result_t;

  // Configuration
  logic [KIND_BITS-1:0] prim_kind_q;
  logic                 cull_en_q, cull_mode_q, clear_mode_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx;

  // Assembly state
  logic [REF_BITS-1:0] slots_q [3];
  logic [REF_BITS-1:0] slots_d [3];
  logic [1:0]          vnum_q, vnum_d;
  logic                odd_q, odd_d;
  logic [1:0]          gpos_q, gpos_d;
  logic                gdrop_q, gdrop_d;
  logic [1:0]          skip_q, skip_d;
  logic                pend_q, pend_d;

  // Result buffer
  result_t    res0_q, res0_d, res1_q, res1_d;
  logic [1:0] cnt_q, cnt_d;

  logic       vtx_acc, prim_pop, kind_valid;
  logic [1:0] vn0, gp0, sk0, wr_idx, pos, n_res;
  logic       od0, gd0, gd1, flag, wr_en;
  logic       emit_tri, emit_rect, tri_rev, both_win;
  result_t    r0, r1;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_PRIM_KIND:  prdata[KIND_BITS-1:0] = prim_kind_q;
      REG_CULL_EN:    prdata[0] = cull_en_q;
      REG_CULL_MODE:  prdata[0] = cull_mode_q;
      REG_CLEAR_MODE: prdata[0] = clear_mode_q;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_kind_q  <= KIND_TRIS;
      cull_en_q    <= 1'b0;
      cull_mode_q  <= 1'b0;
      clear_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PRIM_KIND:  prim_kind_q  <= pwdata[KIND_BITS-1:0];
        REG_CULL_EN:    cull_en_q    <= pwdata[0];
        REG_CULL_MODE:  cull_mode_q  <= pwdata[0];
        REG_CLEAR_MODE: clear_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign vtx_i.ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && prim_o.ready);
  assign vtx_acc      = vtx_i.valid && vtx_i.ready;
  assign prim_pop     = prim_o.valid && prim_o.ready;
  assign kind_valid   = (prim_kind_q <= KIND_RECTS);

  // Start-of-draw view of the state
  assign vn0  = vtx_i.new_draw ? 2'd0 : vnum_q;
  assign od0  = vtx_i.new_draw ? 1'b0 : odd_q;
  assign gp0  = vtx_i.new_draw ? 2'd0 : gpos_q;
  assign gd0  = vtx_i.new_draw ? 1'b0 : gdrop_q;
  assign sk0  = vtx_i.new_draw ? SKIP_RESET : skip_q;
  assign flag = vtx_i.outside | pend_q;
  assign pos  = (gp0 == 2'd3) ? 2'd2 : gp0;
  assign gd1  = gd0 | flag;

  always_comb begin
    vnum_d    = vnum_q;
    odd_d     = odd_q;
    gpos_d    = gpos_q;
    gdrop_d   = gdrop_q;
    skip_d    = skip_q;
    pend_d    = pend_q;
    wr_en     = 1'b0;
    wr_idx    = 2'd0;
    emit_tri  = 1'b0;
    emit_rect = 1'b0;
    tri_rev   = 1'b0;
    unique case (prim_kind_q)
      KIND_STRIP: begin
        wr_en  = 1'b1;
        wr_idx = (vn0 == 2'd3) ? 2'd2 : vn0;
        odd_d  = ~od0;
        gpos_d = gp0;
        gdrop_d = gd0;
        unique case (wr_idx)
          2'd0:    vnum_d = 2'd1;
          2'd1:    vnum_d = 2'd2;
          default: vnum_d = 2'd0;
        endcase
        if (flag) begin
          skip_d = SKIP_RESET;
          pend_d = 1'b0;
        end else if (sk0 != 2'd0) begin
          skip_d = sk0 - 2'd1;
        end else begin
          skip_d   = sk0;
          emit_tri = 1'b1;
          tri_rev  = ~cull_mode_q ^ od0;
        end
      end
      KIND_FAN: begin
        wr_en   = 1'b1;
        gpos_d  = gp0;
        gdrop_d = gd0;
        if (vn0 == 2'd0) begin
          wr_idx = 2'd0;
          pend_d = pend_q | vtx_i.outside;
          skip_d = SKIP_HUB;
          vnum_d = 2'd1;
          odd_d  = 1'b1;
        end else begin
          wr_idx = od0 ? 2'd1 : 2'd2;
          vnum_d = vn0;
          odd_d  = ~od0;
          if (flag) begin
            skip_d = SKIP_RESET;
            pend_d = 1'b0;
          end else if (sk0 != 2'd0) begin
            skip_d = sk0 - 2'd1;
          end else begin
            skip_d   = sk0;
            emit_tri = 1'b1;
            tri_rev  = ~cull_mode_q ^ od0;
          end
        end
      end
      KIND_POINTS, KIND_LINES, KIND_TRIS, KIND_RECTS: begin
        wr_en  = 1'b1;
        wr_idx = pos;
        vnum_d = vn0;
        odd_d  = od0;
        skip_d = sk0;
        if (!gd0 && flag) begin
          pend_d = 1'b0;
        end
        if ((prim_kind_q == KIND_POINTS) ||
            ((prim_kind_q == KIND_TRIS) && (pos == 2'd2)) ||
            ((prim_kind_q != KIND_TRIS) && (pos != 2'd0))) begin
          gpos_d    = 2'd0;
          gdrop_d   = 1'b0;
          emit_tri  = !gd1 && (prim_kind_q == KIND_TRIS);
          emit_rect = !gd1 && (prim_kind_q == KIND_RECTS);
          tri_rev   = ~cull_mode_q;
        end else begin
          gpos_d  = pos + 2'd1;
          gdrop_d = gd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    slots_d = slots_q;
    if (wr_en) begin
      slots_d[wr_idx] = vtx_i.vertex_ref;
    end
  end

  // Primitive selection
  assign both_win = !cull_en_q || clear_mode_q;

  always_comb begin
    r0    = '{shape: SHAPE_TRI, a: slots_d[0], b: slots_d[1], c: slots_d[2], last: 1'b1};
    r1    = '{shape: SHAPE_TRI, a: slots_d[2], b: slots_d[1], c: slots_d[0], last: 1'b1};
    n_res = 2'd0;
    if (emit_rect) begin
      r0    = '{shape: SHAPE_RECT, a: slots_d[0], b: slots_d[1], c: '0, last: 1'b1};
      n_res = 2'd1;
    end else if (emit_tri) begin
      if (both_win) begin
        r0.last = 1'b0;
        n_res   = 2'd2;
      end else begin
        if (tri_rev) begin
          r0 = r1;
        end
        n_res = 2'd1;
      end
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    res0_d = res0_q;
    res1_d = res1_q;
    if (vtx_acc) begin
      cnt_d  = kind_valid ? n_res : 2'd0;
      res0_d = r0;
      res1_d = r1;
    end else if (prim_pop) begin
      cnt_d  = cnt_q - 2'd1;
      res0_d = res1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '{default: '0};
      vnum_q  <= 2'd0;
      odd_q   <= 1'b0;
      gpos_q  <= 2'd0;
      gdrop_q <= 1'b0;
      skip_q  <= SKIP_RESET;
      pend_q  <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (vtx_acc) begin
        slots_q <= slots_d;
        vnum_q  <= vnum_d;
        odd_q   <= odd_d;
        gpos_q  <= gpos_d;
        gdrop_q <= gdrop_d;
        skip_q  <= skip_d;
        pend_q  <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  assign prim_o.valid      = (cnt_q != 2'd0);
  assign prim_o.prim_shape = res0_q.shape;
  assign prim_o.ref_a      = res0_q.a;
  assign prim_o.ref_b      = res0_q.b;
  assign prim_o.ref_c      = res0_q.c;
  assign prim_o.last       = res0_q.last;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> prim_o.last)
    else $error("final buffered primitive not marked last");

  a_skip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q != 2'd3)
    else $error("skip counter out of range");

  a_vnum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vnum_q != 2'd3)
    else $error("vertex number out of range");

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for primitive_assembler_cull_order_unit: directed and random vertex streams
// with a built-in predictor of the assembled primitives. Depends on pacu_pkg and pacu_if.sv.
module testbench;
  import pacu_pkg::*;

  localparam int unsigned REF_BITS      = REF_BITS_DEF;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned PRINT_CAP     = 50;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic                shape;
    logic [REF_BITS-1:0] a;
    logic [REF_BITS-1:0] b;
    logic [REF_BITS-1:0] c;
    logic                last;
  } primitive_t;

  logic clk_i;
  logic rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  pacu_vtx_if  #(.REF_BITS(REF_BITS)) vtx_ch ();
  pacu_prim_if #(.REF_BITS(REF_BITS)) prim_ch ();

  primitive_assembler_cull_order_unit #(.REF_BITS(REF_BITS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vtx_i   (vtx_ch),
    .prim_o  (prim_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  primitive_t pending_primitives[$];
  int unsigned mismatch_count   = 0;
  int unsigned idle_cycles      = 0;
  int unsigned hold_off_cycles  = 0;
  bit          src_idling       = 1'b1;
  bit          sink_idling      = 1'b1;

  logic [KIND_BITS-1:0] kind_q;
  logic                 cull_en_q, cull_mode_q, clear_q;
  logic [REF_BITS-1:0]  slot_q [3];
  logic [1:0]           vnum_q, gpos_q, skip_q;
  logic                 odd_q, gdrop_q, pend_q;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void reset_assembler_model();
    kind_q      = KIND_TRIS;
    cull_en_q   = 1'b0;
    cull_mode_q = 1'b0;
    clear_q     = 1'b0;
    for (int i = 0; i < 3; i++) slot_q[i] = '0;
    vnum_q  = '0;
    gpos_q  = '0;
    skip_q  = SKIP_RESET;
    odd_q   = 1'b0;
    gdrop_q = 1'b0;
    pend_q  = 1'b0;
  endfunction

  function automatic void push_primitive(input logic shape, input logic [REF_BITS-1:0] a,
                                         input logic [REF_BITS-1:0] b,
                                         input logic [REF_BITS-1:0] c);
    primitive_t p;
    p.shape = shape;
    p.a     = a;
    p.b     = b;
    p.c     = c;
    p.last  = 1'b0;
    pending_primitives.push_back(p);
  endfunction

  function automatic void emit_triangle(input logic reversed);
    if (!cull_en_q || clear_q) begin
      push_primitive(SHAPE_TRI, slot_q[0], slot_q[1], slot_q[2]);
      push_primitive(SHAPE_TRI, slot_q[2], slot_q[1], slot_q[0]);
    end else if (reversed) begin
      push_primitive(SHAPE_TRI, slot_q[2], slot_q[1], slot_q[0]);
    end else begin
      push_primitive(SHAPE_TRI, slot_q[0], slot_q[1], slot_q[2]);
    end
  endfunction

  // Triangle suppression shared by strips and fans.
  function automatic void strip_fan_emit(input logic outs);
    if (outs || pend_q) begin
      skip_q = SKIP_RESET;
      pend_q = 1'b0;
    end else if (skip_q != 0) begin
      skip_q = skip_q - 1'b1;
    end else begin
      emit_triangle((cull_mode_q == 1'b0) ^ odd_q);
    end
  endfunction

  function automatic void predict_vertex(input logic [REF_BITS-1:0] vref, input logic outs,
                                         input logic nd);
    int unsigned queued_at_start;
    int unsigned group_size;
    int unsigned pos;
    logic [1:0]  slot;
    queued_at_start = pending_primitives.size();
    if (kind_q > KIND_RECTS) return;
    if (nd) begin
      vnum_q  = '0;
      odd_q   = 1'b0;
      gpos_q  = '0;
      gdrop_q = 1'b0;
      skip_q  = SKIP_RESET;
    end
    if (kind_q == KIND_STRIP) begin
      slot = (vnum_q < 3) ? vnum_q : 2'd2;
      slot_q[slot] = vref;
      strip_fan_emit(outs);
      vnum_q = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
      odd_q  = ~odd_q;
    end else if (kind_q == KIND_FAN) begin
      if (vnum_q == 0) begin
        slot_q[0] = vref;
        pend_q    = pend_q | outs;
        skip_q    = SKIP_HUB;
        vnum_q    = 2'd1;
        odd_q     = 1'b1;
      end else begin
        slot_q[odd_q ? 1 : 2] = vref;
        strip_fan_emit(outs);
        odd_q = ~odd_q;
      end
    end else begin
      group_size = (kind_q == KIND_POINTS) ? 1 : (kind_q == KIND_TRIS) ? 3 : 2;
      pos = (gpos_q < 3) ? gpos_q : 2;
      slot_q[pos] = vref;
      if (!gdrop_q && (outs || pend_q)) begin
        gdrop_q = 1'b1;
        pend_q  = 1'b0;
      end
      if (pos + 1 >= group_size) begin
        if (!gdrop_q) begin
          if (kind_q == KIND_TRIS) begin
            emit_triangle(cull_mode_q == 1'b0);
          end else if (kind_q == KIND_RECTS) begin
            push_primitive(SHAPE_RECT, slot_q[0], slot_q[1], '0);
          end
        end
        gpos_q  = '0;
        gdrop_q = 1'b0;
      end else begin
        gpos_q = 2'(pos + 1);
      end
    end
    if (pending_primitives.size() > queued_at_start)
      pending_primitives[pending_primitives.size() - 1].last = 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [REF_BITS-1:0] random_ref();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return REF_BITS'($urandom());
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_vertex(input logic [REF_BITS-1:0] vref, input logic outs,
                             input logic nd);
    if (src_idling && $urandom_range(0, 99) < 30) begin
      vtx_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    vtx_ch.valid      <= 1'b1;
    vtx_ch.vertex_ref <= vref;
    vtx_ch.outside    <= outs;
    vtx_ch.new_draw   <= nd;
    do @(posedge clk_i); while (!vtx_ch.ready);
    predict_vertex(vref, outs, nd);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PRIM_KIND:  kind_q      = value[KIND_BITS-1:0];
      REG_CULL_EN:    cull_en_q   = value[0];
      REG_CULL_MODE:  cull_mode_q = value[0];
      REG_CLEAR_MODE: clear_q     = value[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, drain every expected primitive, then let in-flight vertices settle.
  task automatic quiesce();
    vtx_ch.valid <= 1'b0;
    while (pending_primitives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [KIND_BITS-1:0] kind, input logic cen,
                            input logic cmode, input logic clr);
    quiesce();
    write_reg(REG_PRIM_KIND, 32'(kind));
    write_reg(REG_CULL_EN, 32'(cen));
    write_reg(REG_CULL_MODE, 32'(cmode));
    write_reg(REG_CLEAR_MODE, 32'(clr));
  endtask

  task automatic test_triangle_lists();
    send_vertex(16'h0000, 1'b0, 1'b1);
    send_vertex(16'hFFFF, 1'b0, 1'b0);
    send_vertex(16'h8001, 1'b0, 1'b0);
    send_vertex(16'h1234, 1'b0, 1'b0);
    send_vertex(16'h5678, 1'b1, 1'b0);
    send_vertex(16'h9ABC, 1'b1, 1'b0);
    set_config(KIND_TRIS, 1'b1, 1'b0, 1'b0);
    send_vertex(16'h0001, 1'b0, 1'b1);
    send_vertex(16'h7FFF, 1'b0, 1'b0);
    send_vertex(16'hFFFE, 1'b0, 1'b0);
    set_config(KIND_TRIS, 1'b1, 1'b1, 1'b1);
    send_vertex(16'hAAAA, 1'b0, 1'b1);
    send_vertex(16'h5555, 1'b0, 1'b0);
    send_vertex(16'hFFFF, 1'b0, 1'b0);
  endtask

  task automatic test_strips();
    set_config(KIND_STRIP, 1'b1, 1'b1, 1'b0);
    send_vertex(16'h0010, 1'b0, 1'b1);
    send_vertex(16'h0011, 1'b0, 1'b0);
    send_vertex(16'h0012, 1'b0, 1'b0);
    send_vertex(16'h0013, 1'b0, 1'b0);
    send_vertex(16'h0014, 1'b1, 1'b0);
    send_vertex(16'h0015, 1'b0, 1'b0);
  endtask

  task automatic test_fans();
    set_config(KIND_FAN, 1'b0, 1'b0, 1'b0);
    send_vertex(16'h0100, 1'b1, 1'b1);
    send_vertex(16'h0101, 1'b0, 1'b0);
    send_vertex(16'h0102, 1'b0, 1'b0);
    send_vertex(16'h0103, 1'b0, 1'b0);
    send_vertex(16'h0104, 1'b0, 1'b0);
  endtask

  // Rects and points follow without a new draw, so state carries across; lines start one.
  task automatic test_rects_points_lines();
    set_config(KIND_RECTS, 1'b1, 1'b0, 1'b0);
    send_vertex(16'hFFFF, 1'b0, 1'b0);
    send_vertex(16'h0000, 1'b0, 1'b0);
    set_config(KIND_POINTS, 1'b0, 1'b0, 1'b0);
    send_vertex(16'h4321, 1'b1, 1'b0);
    set_config(KIND_LINES, 1'b0, 1'b0, 1'b0);
    send_vertex(16'h2222, 1'b0, 1'b1);
    send_vertex(16'h3333, 1'b0, 1'b0);
  endtask

  task automatic test_unused_kinds();
    set_config(KIND_UNUSED_LO, 1'b0, 1'b0, 1'b0);
    send_vertex(16'hBEEF, 1'b1, 1'b1);
    set_config(KIND_UNUSED_HI, 1'b0, 1'b0, 1'b0);
    send_vertex(16'hCAFE, 1'b0, 1'b0);
    set_config(KIND_TRIS, 1'b0, 1'b0, 1'b0);
    send_vertex(16'h0AAA, 1'b0, 1'b0);
  endtask

  task automatic test_random_draws();
    int unsigned     quota;
    int unsigned     sent;
    int unsigned     draw_len;
    int unsigned     k;
    logic [KIND_BITS-1:0] kind;
    logic [2:0]      cull_bits;
    for (int phase = 0; phase < 24; phase++) begin
      kind = (phase < 12) ? KIND_BITS'(phase % 6) : KIND_BITS'($urandom_range(0, 5));
      if (phase == 0) cull_bits = 3'b000;
      else if (phase == 1) cull_bits = 3'b111;
      else cull_bits = 3'($urandom_range(0, 7));
      set_config(kind, cull_bits[2], cull_bits[1], cull_bits[0]);
      src_idling  = ($urandom_range(0, 3) != 0);
      sink_idling = ($urandom_range(0, 3) != 0);
      quota = $urandom_range(50, 70);
      sent  = 0;
      if ($urandom_range(0, 2) == 0) begin
        k = $urandom_range(1, 3);
        repeat (k) begin
          send_vertex(random_ref(), 1'b0, 1'b0);
          sent++;
        end
      end
      while (sent < quota) begin
        if ($urandom_range(0, 99) < 85) begin
          draw_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                 : $urandom_range(1, 8);
          for (k = 0; k < draw_len; k++) begin
            send_vertex(random_ref(), $urandom_range(0, 99) < 6, k == 0);
            sent++;
          end
        end else begin
          send_vertex(random_ref(), $urandom_range(0, 99) < 40, 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    set_config(KIND_TRIS, 1'b0, 1'b0, 1'b0);
    src_idling      = 1'b0;
    sink_idling     = 1'b0;
    hold_off_cycles = 300;
    for (int k = 0; k < 60; k++) send_vertex(random_ref(), 1'b0, k == 0);
    src_idling  = 1'b1;
    sink_idling = 1'b1;
  endtask

  initial begin
    reset_assembler_model();
    prim_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_cycles != 0) begin
        prim_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else if (sink_idling && $urandom_range(0, 99) < 30) begin
        prim_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end else begin
        prim_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_primitives
    primitive_t want;
    if (rst_ni && prim_ch.valid && prim_ch.ready) begin
      if (pending_primitives.size() == 0) begin
        report_mismatch("primitive with none expected, ref_a", 32'(prim_ch.ref_a), '0);
      end else begin
        want = pending_primitives.pop_front();
        if (prim_ch.prim_shape !== want.shape)
          report_mismatch("prim_shape", 32'(prim_ch.prim_shape), 32'(want.shape));
        if (prim_ch.ref_a !== want.a)
          report_mismatch("ref_a", 32'(prim_ch.ref_a), 32'(want.a));
        if (prim_ch.ref_b !== want.b)
          report_mismatch("ref_b", 32'(prim_ch.ref_b), 32'(want.b));
        if (prim_ch.ref_c !== want.c)
          report_mismatch("ref_c", 32'(prim_ch.ref_c), 32'(want.c));
        if (prim_ch.last !== want.last)
          report_mismatch("last", 32'(prim_ch.last), 32'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (vtx_ch.valid && vtx_ch.ready) || (prim_ch.valid && prim_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("primitive_assembler_cull_order_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    vtx_ch.valid      <= 1'b0;
    vtx_ch.vertex_ref <= '0;
    vtx_ch.outside    <= 1'b0;
    vtx_ch.new_draw   <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_triangle_lists();
    test_strips();
    test_fans();
    test_rects_points_lines();
    test_unused_kinds();
    test_random_draws();
    test_output_backpressure();
    vtx_ch.valid <= 1'b0;
    while (pending_primitives.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("primitive_assembler_cull_order_unit test passed");
    end else begin
      $display("primitive_assembler_cull_order_unit test failed");
    end
    $finish;
  end

endmodule
